FILE: rtl/lrn_pkg.sv
// Shared types and codes for the link role negotiation block.
// Used by lrn_step and link_role_negotiation_fsm_core; no dependencies.
package lrn_pkg;

   localparam int unsigned CountWidth   = 7;
   localparam int unsigned AttemptWidth = 4;
   localparam int unsigned LimitWidth   = 6;
   localparam int unsigned CsrDataWidth = 6;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 24;

   localparam logic [CountWidth-1:0] CountMax = '1;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_PROBES_PER_PHASE    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SEARCH_RETRY_LIMIT  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_CONFIRM_RETRY_LIMIT = 2'd2;

   localparam logic [AttemptWidth-1:0] PROBES_RESET        = 4'd4;
   localparam logic [LimitWidth-1:0]   SEARCH_LIMIT_RESET  = 6'd30;
   localparam logic [LimitWidth-1:0]   CONFIRM_LIMIT_RESET = 6'd10;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_OUTCOME = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ACT_PROBE   = 2'd0,
      ACT_TOGGLE  = 2'd1,
      ACT_CONFIRM = 2'd2,
      ACT_DONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_SEARCH  = 3'b010,
      PH_CONFIRM = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [AttemptWidth-1:0] attempt;
      logic [CountWidth-1:0]   search_fail;
      logic [CountWidth-1:0]   confirm_fail;
      logic                    role;
      logic                    last_outcome;
   } state_type;

   typedef struct packed {
      logic [AttemptWidth-1:0] probes_per_phase;
      logic [LimitWidth-1:0]   search_retry_limit;
      logic [LimitWidth-1:0]   confirm_retry_limit;
   } cfg_type;

   typedef struct packed {
      op_type operation;
      logic   probe_ok;
   } item_type;

   typedef struct packed {
      logic [CountWidth-1:0] confirm_failures;
      logic [CountWidth-1:0] search_failures;
      logic                  succeeded;
      logic                  role;
      action_type            action;
   } result_type;

endpackage

FILE: rtl/lrn_step.sv
// Next-state and result logic for one negotiation transaction.
// Depends on lrn_pkg; purely combinational, sits between the input and result registers.
module lrn_step (
   input  lrn_pkg::state_type  cur_state,
   input  lrn_pkg::cfg_type    cfg,
   input  lrn_pkg::item_type   item,
   output lrn_pkg::state_type  nxt_state,
   output lrn_pkg::result_type result
);
   import lrn_pkg::*;

   logic [AttemptWidth-1:0] attempt_inc;
   logic [CountWidth-1:0]   search_bump;
   logic [CountWidth-1:0]   confirm_bump;

   assign attempt_inc  = cur_state.attempt + AttemptWidth'(1);
   assign search_bump  = (cur_state.search_fail == CountMax) ? CountMax
                         : cur_state.search_fail + CountWidth'(1);
   assign confirm_bump = (cur_state.confirm_fail == CountMax) ? CountMax
                         : cur_state.confirm_fail + CountWidth'(1);

   always_comb begin
      action_type act;
      logic       succ;
      state_type  ns;
      act  = ACT_PROBE;
      succ = 1'b0;
      ns   = cur_state;
      if (item.operation == OP_START) begin
         ns.phase        = PH_SEARCH;
         ns.attempt      = '0;
         ns.search_fail  = '0;
         ns.confirm_fail = '0;
         act             = ACT_PROBE;
      end else begin
         unique case (cur_state.phase)
            PH_SEARCH: begin
               if (item.probe_ok) begin
                  ns.phase   = PH_CONFIRM;
                  ns.attempt = '0;
                  act        = ACT_CONFIRM;
               end else if (attempt_inc < cfg.probes_per_phase) begin
                  ns.attempt = attempt_inc;
                  act        = ACT_PROBE;
               end else begin
                  // The round is spent: count it and either flip role or give up.
                  ns.attempt     = '0;
                  ns.search_fail = search_bump;
                  if (search_bump <= {1'b0, cfg.search_retry_limit}) begin
                     ns.role = ~cur_state.role;
                     act     = ACT_TOGGLE;
                  end else begin
                     ns.phase        = PH_IDLE;
                     ns.last_outcome = 1'b0;
                     act             = ACT_DONE;
                  end
               end
            end
            PH_CONFIRM: begin
               if (item.probe_ok) begin
                  if (attempt_inc >= cfg.probes_per_phase) begin
                     ns.phase        = PH_IDLE;
                     ns.attempt      = '0;
                     ns.last_outcome = 1'b1;
                     act             = ACT_DONE;
                     succ            = 1'b1;
                  end else begin
                     ns.attempt = attempt_inc;
                     act        = ACT_PROBE;
                  end
               end else begin
                  ns.attempt      = '0;
                  ns.confirm_fail = confirm_bump;
                  if (confirm_bump <= {1'b0, cfg.confirm_retry_limit}) begin
                     ns.phase = PH_SEARCH;
                     act      = ACT_PROBE;
                  end else begin
                     ns.phase        = PH_IDLE;
                     ns.last_outcome = 1'b0;
                     act             = ACT_DONE;
                  end
               end
            end
            default: begin
               // An outcome with no negotiation running reports the last verdict.
               ns.phase = PH_IDLE;
               act      = ACT_DONE;
               succ     = cur_state.last_outcome;
            end
         endcase
      end
      nxt_state               = ns;
      result.action           = act;
      result.role             = ns.role;
      result.succeeded        = succ;
      result.search_failures  = ns.search_fail;
      result.confirm_failures = ns.confirm_fail;
   end

endmodule

FILE: rtl/link_role_negotiation_fsm_core.sv
// Top level of the link role negotiation block: input register, state, result register.
// Depends on lrn_pkg and lrn_step.
//
//  channel | direction | transaction contents
//  req_    | in        | tuser: operation; tdata[0]: probe_ok
//  rsp_    | out       | tdata: action, role, succeeded, search/confirm failure counts
//  csr_    | in        | write enable, register index, write data
//
// A transaction accepted on req_ is held in the input register, then in the result register,
// and shows up on rsp_ from there. lrn_step is combinational between the two registers,
// so one new transaction can be taken every cycle while rsp_ is not stalled.
// A stalled rsp_ holds the result register; the input register keeps taking one more
// transaction, then req_tready drops until the result moves on.
// Reset is synchronous and returns all state and configuration to defaults.
module link_role_negotiation_fsm_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [lrn_pkg::ReqDataWidth-1:0]          req_tdata,  // [0] probe_ok
   input  logic                                     req_tuser,  // [0] operation
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [1:0] action, [2] role, [3] succeeded, [10:4] search_failures,
   // [17:11] confirm_failures, upper bits zero
   output logic [lrn_pkg::RspDataWidth-1:0]          rsp_tdata,
   input  logic                                     csr_we,
   input  logic [lrn_pkg::CsrIdxWidth-1:0]           csr_index,
   input  logic [lrn_pkg::CsrDataWidth-1:0]          csr_wdata
);
   import lrn_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   result_type step_result;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   lrn_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .item      (item_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROBES_PER_PHASE:    cfg_in.probes_per_phase    = csr_wdata[AttemptWidth-1:0];
            CSR_SEARCH_RETRY_LIMIT:  cfg_in.search_retry_limit  = csr_wdata[LimitWidth-1:0];
            CSR_CONFIRM_RETRY_LIMIT: cfg_in.confirm_retry_limit = csr_wdata[LimitWidth-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         state_ff.phase              <= PH_IDLE;
         state_ff.attempt            <= '0;
         state_ff.search_fail        <= '0;
         state_ff.confirm_fail       <= '0;
         state_ff.role               <= 1'b1;
         state_ff.last_outcome       <= 1'b0;
         cfg_ff.probes_per_phase     <= PROBES_RESET;
         cfg_ff.search_retry_limit   <= SEARCH_LIMIT_RESET;
         cfg_ff.confirm_retry_limit  <= CONFIRM_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.operation <= op_type'(req_tuser);
         item_ff.probe_ok  <= req_tdata[0];
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RspDataWidth - $bits(result_type))'(0), result_ff};

`ifndef SYNTHESIS
   // A verdict flag is only ever raised on a finished result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[1:0] == ACT_DONE)
      else $error("succeeded set on a non-final result");

   // With no negotiation running the attempt counter rests at zero.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> state_ff.attempt == '0)
      else $error("attempt count nonzero while idle");

   // State changes only when a transaction moves into the result register.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("negotiation state changed without a transaction");

   // A held input transaction is not dropped while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |=> in_valid_ff && $stable(item_ff))
      else $error("pending transaction lost during output stall");
`endif

endmodule
